[hw/rtl/timing_wheel_scheduler_assert.svh]
// Assertion macros shared by the timing wheel scheduler.
`ifndef TIMING_WHEEL_SCHEDULER_ASSERT_SVH
`define TIMING_WHEEL_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWS_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("timing wheel scheduler assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TWS_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("timing wheel scheduler assertion failed");

`endif

[hw/rtl/twsch_pkg.sv]
package twsch_pkg;

  localparam int TIMEOUT_W  = 32;
  localparam int INTERVAL_W = 16;
  localparam int HANDLE_W   = 6;

  typedef enum logic [1:0] {
    K_ADD    = 2'd0,
    K_CANCEL = 2'd1,
    K_TICK   = 2'd2,
    K_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_NEG       = 3'd1,
    ST_FULL      = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_UNUSED    = 3'd4,
    ST_EXPIRED   = 3'd5,
    ST_QUIET     = 3'd6
  } status_t;

  typedef struct packed {
    kind_t                        kind;
    logic signed [TIMEOUT_W-1:0]  timeout;
    logic        [HANDLE_W-1:0]   timer_handle;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [HANDLE_W-1:0]   result_handle;
    logic                  last;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DIV1, S_SLOT, S_AHRD, S_ALINK, S_AFIX,
    S_URD, S_UHRD, S_UWR, S_THRD, S_TIDX, S_TCHK, S_TEVAL, S_TEND
  } state_t;

  typedef struct packed {
    logic load;
    logic div_go;
    logic quo_ld;
    logic slot_ld;
    logic head_rd_s;
    logic add_link;
    logic add_fix;
    logic emit_neg;
    logic emit_full;
    logic emit_unused;
    logic tgt_hin;
    logic idx_ld;
    logic dec_rounds;
    logic unl_latch;
    logic unl_wr;
    logic tick_end;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  neg;
    logic  full;
    logic  hin_ok;
    logic  div_done;
    logic  idx_none;
    logic  guard_hit;
    logic  rounds_nz;
  } sts_t;

endpackage

[hw/rtl/twsch_ram.sv]
module twsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/twsch_div.sv]
module twsch_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quo
);

  logic        running;
  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [16:0] trial;
  logic [17:0] diff;
  logic        ge;

  always_comb begin
    trial = {rem, quo[31]};
    diff  = {1'b0, trial} - {2'b00, divisor};
    ge    = ~diff[17];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo <= dividend;
      rem <= '0;
    end else if (running) begin
      quo <= {quo[30:0], ge};
      rem <= ge ? diff[15:0] : trial[15:0];
    end
  end

endmodule

[hw/rtl/twsch_ctrl.sv]
module twsch_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  twsch_pkg::sts_t sts,
  output twsch_pkg::cmd_t cmd,
  output logic            busy
);
  import twsch_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_DECODE;
      S_DECODE: begin
        unique case (sts.kind)
          K_ADD:    state_next = (sts.neg || sts.full) ? S_IDLE : S_DIV1;
          K_CANCEL: state_next = sts.hin_ok ? S_URD : S_IDLE;
          K_TICK:   state_next = S_THRD;
          K_NONE:   state_next = S_IDLE;
        endcase
      end
      S_DIV1:   if (sts.div_done) state_next = S_SLOT;
      S_SLOT:   state_next = S_AHRD;
      S_AHRD:   state_next = S_ALINK;
      S_ALINK:  state_next = S_AFIX;
      S_AFIX:   state_next = S_IDLE;
      S_URD:    state_next = S_UHRD;
      S_UHRD:   state_next = S_UWR;
      S_UWR:    state_next = (sts.kind == K_TICK) ? S_TCHK : S_IDLE;
      S_THRD:   state_next = S_TIDX;
      S_TIDX:   state_next = S_TCHK;
      S_TCHK:   state_next = (sts.idx_none || sts.guard_hit) ? S_TEND : S_TEVAL;
      S_TEVAL:  state_next = sts.rounds_nz ? S_TCHK : S_UWR;
      S_TEND:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE:   cmd.load = start;
      S_DECODE: begin
        if (sts.kind == K_ADD) begin
          priority if (sts.neg) begin
            cmd.emit_neg = 1'b1;
          end else if (sts.full) begin
            cmd.emit_full = 1'b1;
          end else begin
            cmd.div_go = 1'b1;
          end
        end else if (sts.kind == K_CANCEL) begin
          cmd.tgt_hin     = sts.hin_ok;
          cmd.emit_unused = ~sts.hin_ok;
        end
      end
      S_DIV1:   cmd.quo_ld     = sts.div_done;
      S_SLOT:   cmd.slot_ld    = 1'b1;
      S_AHRD:   cmd.head_rd_s  = 1'b1;
      S_ALINK:  cmd.add_link   = 1'b1;
      S_AFIX:   cmd.add_fix    = 1'b1;
      S_URD:    cmd            = '0;
      S_UHRD:   cmd.unl_latch  = 1'b1;
      S_UWR:    cmd.unl_wr     = 1'b1;
      S_THRD:   cmd            = '0;
      S_TIDX:   cmd.idx_ld     = 1'b1;
      S_TCHK:   cmd            = '0;
      S_TEVAL: begin
        cmd.dec_rounds = sts.rounds_nz;
        cmd.unl_latch  = ~sts.rounds_nz;
      end
      S_TEND:   cmd.tick_end   = 1'b1;
      default:  cmd            = '0;
    endcase
  end

endmodule

[hw/rtl/twsch_dp.sv]
module twsch_dp #(
  parameter int SLOTS      = 60,
  parameter int MAX_TIMERS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  twsch_pkg::req_t                    request,
  input  logic                               cfg_we,
  input  logic [twsch_pkg::INTERVAL_W-1:0]   cfg_data,
  input  twsch_pkg::cmd_t                    cmd,
  output twsch_pkg::sts_t                    sts,
  output logic                               strobe,
  output twsch_pkg::rsp_t                    result
);
  import twsch_pkg::*;

  localparam int IW = $clog2(MAX_TIMERS);
  localparam int LW = IW + 1;
  localparam int SW = $clog2(SLOTS);
  localparam logic [LW-1:0] NONE = LW'(MAX_TIMERS);
  // Ticks stay below 2**31, so this reciprocal gives the exact quotient by SLOTS.
  localparam int RSH = 31 + SW;
  localparam logic [31:0] RECIP =
    32'(((64'd1 << RSH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

  logic [INTERVAL_W-1:0] interval;
  req_t                  req_q;
  logic [IW-1:0]         h_q;
  logic [SW-1:0]         cs;
  logic [SW-1:0]         s_q;
  logic [31:0]           rounds_q;
  logic [SW-1:0]         tlo_q;
  logic [MAX_TIMERS-1:0] in_use;
  logic [SLOTS-1:0]      head_valid;
  logic                  hv_q;
  logic [LW-1:0]         tgt;
  logic [LW-1:0]         guard;
  logic [LW-1:0]         nx_q;
  logic [LW-1:0]         pv_q;
  logic [SW-1:0]         home_q;
  logic                  pend_v;
  logic [LW-1:0]         pend_h;

  logic [IW-1:0]         free_h;
  logic [INTERVAL_W-1:0] si;
  logic [31:0]           ticks;
  logic [31:0]           dividend;
  logic [15:0]           divisor;
  logic                  div_done;
  logic [31:0]           quo;
  logic [62:0]           prod;
  logic [SW-1:0]         rlo;
  logic [SW-1:0]         rmod;
  logic [SW:0]           ssum;
  logic [SW-1:0]         s_c;

  logic [LW-1:0]         next_out, prev_out, head_raw, head_out;
  logic [31:0]           rnd_out;
  logic [SW-1:0]         home_out;
  logic                  nx_ok, pv_ok, is_head;

  logic                  next_we, prev_we, rnd_we, home_we, head_we;
  logic [IW-1:0]         next_wa, prev_wa, rnd_wa;
  logic [LW-1:0]         next_wd, prev_wd, head_wd;
  logic [31:0]           rnd_wd;
  logic [SW-1:0]         head_wa, head_ra;

  always_comb begin
    free_h = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_h = IW'(i);
      end
    end
  end

  always_comb begin
    si       = (interval == '0) ? INTERVAL_W'(1) : interval;
    ticks    = (quo == '0) ? 32'd1 : quo;
    dividend = 32'(req_q.timeout);
    divisor  = si;
    prod     = 63'(ticks) * 63'(RECIP);
    rlo      = SW'(rounds_q[SW-1:0] * SW'(SLOTS));
    rmod     = tlo_q - rlo;
    ssum     = {1'b0, cs} + {1'b0, rmod};
    s_c      = (ssum >= (SW+1)'(SLOTS)) ? SW'(ssum - (SW+1)'(SLOTS)) : ssum[SW-1:0];
  end

  twsch_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quo      (quo)
  );

  always_comb begin
    head_out = hv_q ? head_raw : NONE;
    nx_ok    = nx_q < NONE;
    pv_ok    = pv_q < NONE;
    is_head  = head_out == tgt;
  end

  always_comb begin
    priority if (cmd.unl_latch) begin
      head_ra = home_out;
    end else if (cmd.head_rd_s) begin
      head_ra = s_q;
    end else begin
      head_ra = cs;
    end
  end

  always_comb begin
    next_we = 1'b0; next_wa = h_q; next_wd = head_out;
    prev_we = 1'b0; prev_wa = h_q; prev_wd = NONE;
    rnd_we  = 1'b0; rnd_wa  = h_q; rnd_wd  = rounds_q;
    home_we = cmd.add_link;
    head_we = 1'b0; head_wa = s_q; head_wd = LW'(h_q);
    priority if (cmd.add_link) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      rnd_we  = 1'b1;
      head_we = 1'b1;
    end else if (cmd.add_fix) begin
      prev_we = nx_ok;
      prev_wa = nx_q[IW-1:0];
      prev_wd = LW'(h_q);
    end else if (cmd.dec_rounds) begin
      rnd_we = 1'b1;
      rnd_wa = tgt[IW-1:0];
      rnd_wd = rnd_out - 32'd1;
    end else if (cmd.unl_wr) begin
      prev_we = nx_ok;
      prev_wa = nx_q[IW-1:0];
      prev_wd = is_head ? NONE : pv_q;
      next_we = ~is_head & pv_ok;
      next_wa = pv_q[IW-1:0];
      next_wd = nx_q;
      head_we = is_head;
      head_wa = home_q;
      head_wd = nx_q;
    end
  end

  twsch_ram #(.WIDTH(LW), .DEPTH(MAX_TIMERS)) u_next (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(tgt[IW-1:0]), .rdata(next_out)
  );

  twsch_ram #(.WIDTH(LW), .DEPTH(MAX_TIMERS)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .raddr(tgt[IW-1:0]), .rdata(prev_out)
  );

  twsch_ram #(.WIDTH(32), .DEPTH(MAX_TIMERS)) u_rounds (
    .clk(clk), .we(rnd_we), .waddr(rnd_wa), .wdata(rnd_wd),
    .raddr(tgt[IW-1:0]), .rdata(rnd_out)
  );

  twsch_ram #(.WIDTH(SW), .DEPTH(MAX_TIMERS)) u_home (
    .clk(clk), .we(home_we), .waddr(h_q), .wdata(s_q),
    .raddr(tgt[IW-1:0]), .rdata(home_out)
  );

  twsch_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
    .raddr(head_ra), .rdata(head_raw)
  );

  always_comb begin
    sts.kind      = req_q.kind;
    sts.neg       = req_q.timeout[TIMEOUT_W-1];
    sts.full      = &in_use;
    sts.hin_ok    = (32'(req_q.timer_handle) < MAX_TIMERS) &&
                    in_use[req_q.timer_handle[IW-1:0]];
    sts.div_done  = div_done;
    sts.idx_none  = tgt >= NONE;
    sts.guard_hit = guard == NONE;
    sts.rounds_nz = rnd_out != '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval   <= INTERVAL_W'(1);
      cs         <= '0;
      in_use     <= '0;
      head_valid <= '0;
      strobe     <= 1'b0;
      pend_v     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) begin
        interval <= cfg_data;
      end
      if (head_we) begin
        head_valid[head_wa] <= 1'b1;
      end
      if (cmd.add_link) begin
        in_use[h_q] <= 1'b1;
      end
      if (cmd.unl_wr) begin
        in_use[tgt[IW-1:0]] <= 1'b0;
      end
      if (cmd.emit_neg || cmd.emit_full || cmd.emit_unused || cmd.add_fix ||
          cmd.tick_end || (cmd.unl_wr && (req_q.kind != K_TICK || pend_v))) begin
        strobe <= 1'b1;
      end
      if (cmd.idx_ld) begin
        pend_v <= 1'b0;
      end
      if (cmd.unl_wr && req_q.kind == K_TICK) begin
        pend_v <= 1'b1;
      end
      if (cmd.tick_end) begin
        pend_v <= 1'b0;
        cs     <= (cs == SW'(SLOTS - 1)) ? '0 : cs + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    hv_q <= head_valid[head_ra];
    if (cmd.load) begin
      req_q <= request;
      h_q   <= free_h;
    end
    if (cmd.quo_ld) begin
      tlo_q    <= ticks[SW-1:0];
      rounds_q <= 32'(prod >> RSH);
    end
    if (cmd.slot_ld) begin
      s_q <= s_c;
    end
    if (cmd.add_link) begin
      nx_q <= head_out;
    end
    if (cmd.tgt_hin) begin
      tgt <= LW'(req_q.timer_handle[IW-1:0]);
    end
    if (cmd.idx_ld) begin
      tgt   <= head_out;
      guard <= '0;
    end
    if (cmd.dec_rounds) begin
      tgt   <= next_out;
      guard <= guard + LW'(1);
    end
    if (cmd.unl_latch) begin
      nx_q   <= next_out;
      pv_q   <= prev_out;
      home_q <= home_out;
    end
    if (cmd.unl_wr && req_q.kind == K_TICK) begin
      pend_h <= tgt;
      tgt    <= nx_q;
      guard  <= guard + LW'(1);
    end
    priority if (cmd.emit_neg) begin
      result <= '{status: ST_NEG, result_handle: '0, last: 1'b1};
    end else if (cmd.emit_full) begin
      result <= '{status: ST_FULL, result_handle: '0, last: 1'b1};
    end else if (cmd.emit_unused) begin
      result <= '{status: ST_UNUSED, result_handle: '0, last: 1'b1};
    end else if (cmd.add_fix) begin
      result <= '{status: ST_ADDED, result_handle: HANDLE_W'(h_q), last: 1'b1};
    end else if (cmd.unl_wr && req_q.kind != K_TICK) begin
      result <= '{status: ST_CANCELLED, result_handle: HANDLE_W'(tgt), last: 1'b1};
    end else if (cmd.unl_wr) begin
      result <= '{status: ST_EXPIRED, result_handle: HANDLE_W'(pend_h), last: 1'b0};
    end else if (cmd.tick_end && pend_v) begin
      result <= '{status: ST_EXPIRED, result_handle: HANDLE_W'(pend_h), last: 1'b1};
    end else if (cmd.tick_end) begin
      result <= '{status: ST_QUIET, result_handle: '0, last: 1'b1};
    end
  end

endmodule

[hw/rtl/timing_wheel_scheduler.sv]
// Hashed timing wheel with a pool of MAX_TIMERS timers on SLOTS slots. Raise start with a
// request while busy is low; each result appears on result for exactly one cycle with
// strobe high and cannot be held off, so the receiver must take it when it comes. An add
// waits on the bit-serial divider that divides the timeout by the interval (a reciprocal
// multiplication then splits the ticks into rounds and slot). A tick walks the timer
// list of the current slot, counting down each timer whose rounds are not zero and
// expiring each one whose rounds are zero. An unknown kind keeps busy high for one cycle
// and gives no result. The interval register must be written by the user through
// cfg_valid/cfg_data only while busy is low; the block itself does not enforce it.
module timing_wheel_scheduler #(
  parameter int SLOTS      = 60,
  parameter int MAX_TIMERS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  twsch_pkg::req_t                  request,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [twsch_pkg::INTERVAL_W-1:0] cfg_data,
  output logic                             strobe,
  output twsch_pkg::rsp_t                  result
);
  import twsch_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  twsch_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  twsch_dp #(.SLOTS(SLOTS), .MAX_TIMERS(MAX_TIMERS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .strobe   (strobe),
    .result   (result)
  );

`include "timing_wheel_scheduler_assert.svh"

  `TWS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `TWS_ASSERT_NOW(a_partial_busy, clk, rst, strobe && !result.last, busy)
  `TWS_ASSERT_NOW(a_added_last, clk, rst, strobe && result.status == ST_ADDED, result.last)

endmodule
